// ----- src/sitda_pkg.sv -----
// ----------------------------------------------------------------------------
// sitda_pkg - shared types and constants for the signed integer to ASCII block
// Holds the BCD digit vector type, the ASCII codes and the command struct
// that carries a finished conversion from the converter to the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package sitda_pkg;

    // Magnitude width and decimal digit count of a 32-bit magnitude
    localparam int MAG_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIG_IDX_W  = 4;
    localparam int STEP_W     = 5;

    // ASCII codes
    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_MINUS = 7'd45;

    // Packed BCD digits, digit 0 is the least significant
    typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

    // Converter to emitter command
    typedef struct packed {
        logic load;
        logic neg;
        bcd_t digits;
    } emit_cmd_t;

endpackage

`default_nettype wire

// ----- src/sitda_dabble.sv -----
// ----------------------------------------------------------------------------
// sitda_dabble - iterative binary to BCD converter
// Shift-add-3 unit reused over 32 steps, one magnitude bit per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_dabble (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [sitda_pkg::MAG_W-1:0] magnitude,
    output logic                           done,
    output sitda_pkg::bcd_t                digits
);
    import sitda_pkg::*;

    logic [MAG_W-1:0]  shift_reg, shift_next;
    bcd_t              bcd_reg, bcd_next;
    bcd_t              bcd_adj;
    logic [NUM_DIGITS*4-1:0] adj_flat;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    // Add-3 correction on each digit, then shift in the next magnitude bit
    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            bcd_adj[d] = (bcd_reg[d] >= 4'd5) ? (bcd_reg[d] + 4'd3) : bcd_reg[d];
        end
    end

    // Flat view of the corrected digits for the shift
    assign adj_flat = bcd_adj;

    // Step sequencer
    always_comb
    begin
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        step_next  = step_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = magnitude;
            bcd_next   = '0;
            step_next  = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next   = {adj_flat[NUM_DIGITS*4-2:0], shift_reg[MAG_W-1]};
            shift_next = {shift_reg[MAG_W-2:0], 1'b0};
            step_next  = step_reg + 1'b1;
            if (step_reg == STEP_W'(MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign done   = done_reg;
    assign digits = bcd_reg;

endmodule

`default_nettype wire

// ----- src/sitda_emit.sv -----
// ----------------------------------------------------------------------------
// sitda_emit - character emitter with output register
// Emits the sign and the significant BCD digits as ASCII, one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_emit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sitda_pkg::emit_cmd_t cmd,
    output logic                      busy,
    output logic [6:0]                character,
    output logic                      last,
    output logic                      text_valid,
    input  wire logic                 text_ready
);
    import sitda_pkg::*;

    bcd_t                 bcd_reg, bcd_next;
    logic [DIG_IDX_W-1:0] idx_reg, idx_next;
    logic [DIG_IDX_W-1:0] top_idx;
    logic                 minus_reg, minus_next;
    logic                 busy_reg, busy_next;
    logic                 valid_reg, valid_next;
    logic [6:0]           char_reg, char_next;
    logic                 last_reg, last_next;
    logic                 slot_free;

    // Most significant nonzero digit; zero prints one digit
    always_comb
    begin
        top_idx = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (cmd.digits[d] != 4'd0)
            begin
                top_idx = DIG_IDX_W'(d);
            end
        end
    end

    assign slot_free = !valid_reg || text_ready;

    always_comb
    begin
        bcd_next   = bcd_reg;
        idx_next   = idx_reg;
        minus_next = minus_reg;
        busy_next  = busy_reg;
        valid_next = valid_reg && !text_ready;
        char_next  = char_reg;
        last_next  = last_reg;
        if (cmd.load)
        begin
            bcd_next   = cmd.digits;
            idx_next   = top_idx;
            minus_next = cmd.neg;
            busy_next  = 1'b1;
        end
        else if (busy_reg && slot_free)
        begin
            valid_next = 1'b1;
            if (minus_reg)
            begin
                char_next  = CHAR_MINUS;
                last_next  = 1'b0;
                minus_next = 1'b0;
            end
            else
            begin
                char_next = {3'b000, bcd_reg[idx_reg]} + CHAR_ZERO;
                last_next = (idx_reg == '0);
                if (idx_reg == '0)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        bcd_reg   <= bcd_next;
        idx_reg   <= idx_next;
        minus_reg <= minus_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign busy       = busy_reg;
    assign character  = char_reg;
    assign last       = last_reg;
    assign text_valid = valid_reg;

endmodule

`default_nettype wire

// ----- src/signed_int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii - signed 32-bit integer to decimal ASCII text
// Usage:
//   Input channel value/value_valid/value_ready takes one two's complement
//   integer per transfer. Output channel character/last/text_valid/text_ready
//   gives the decimal text, most significant digit first, '-' ahead of a
//   negative magnitude, no leading zeros, last set on the final character.
//   The most negative input prints -2147483648.
// Timing:
//   After an input transfer the shift-add-3 converter runs 32 steps, one
//   magnitude bit per cycle; its done strobe loads the emitter, which then
//   gives one character per cycle while the receiver takes them, and the
//   sequencer then returns to idle. An item gives N = 1..11 characters.
//   value_ready is low from the input transfer until the sequencer is back
//   in idle after the last character is registered; the last character may
//   still wait in the output register while the next input is taken.
// Reset:
//   rst_n clears the sequencer and output valid; the block is then ready.
//   A stalled receiver holds the current character and pauses emission.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] value,
    input  wire logic        value_valid,
    output logic             value_ready,
    output logic [6:0]       character,
    output logic             last,
    output logic             text_valid,
    input  wire logic        text_ready
);
    import sitda_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic             neg_reg, neg_next;
    logic             accept;
    logic [MAG_W-1:0] magnitude;
    logic             conv_done;
    bcd_t             conv_digits;
    emit_cmd_t        cmd;
    logic             emit_busy;

    assign value_ready = (state_reg == ST_IDLE);
    assign accept      = value_valid && value_ready;
    assign magnitude   = value[31] ? (~value + 32'd1) : value;

    // Converter
    sitda_dabble u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .magnitude (magnitude),
        .done      (conv_done),
        .digits    (conv_digits)
    );

    assign cmd.load   = conv_done;
    assign cmd.neg    = neg_reg;
    assign cmd.digits = conv_digits;

    // Emitter
    sitda_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .busy       (emit_busy),
        .character  (character),
        .last       (last),
        .text_valid (text_valid),
        .text_ready (text_ready)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CONV;
                    neg_next   = value[31];
                end
            end
            ST_CONV:
            begin
                if (conv_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!emit_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
    end

endmodule

`default_nettype wire

// ----- sim/tb_signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii - testbench for the integer to ASCII block
// Sends signed 32-bit values through the valid/ready input channel, predicts
// the decimal character run of each accepted value and checks every output
// transfer in order against it. A directed set covers zero, the extremes and
// digit-count boundaries; random values follow under three idling mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_signed_int_to_decimal_ascii;

    import sitda_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 60;

    typedef struct packed {
        logic [6:0] ch;
        logic       fin;
    } text_char_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic [31:0] value       = '0;
    logic        value_valid = 1'b0;
    logic        value_ready;
    logic [6:0]  character;
    logic        last;
    logic        text_valid;
    logic        text_ready  = 1'b0;

    // Characters still owed by the block, oldest first
    text_char_t expected_text[$];
    int         mismatch_count = 0;
    int         send_idle_pct  = 27;
    int         recv_stall_pct = 83;
    int         idle_cycles    = 0;

    signed_int_to_decimal_ascii dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .value_valid(value_valid),
        .value_ready(value_ready),
        .character  (character),
        .last       (last),
        .text_valid (text_valid),
        .text_ready (text_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Decimal text of one value: optional minus, digits MSD first, no leading zeros
    function automatic void predict_text(input logic [31:0] v);
        logic [31:0] mag;
        logic [3:0]  digits [NUM_DIGITS];
        int          nd;
        text_char_t  tc;
        nd  = 0;
        mag = v[31] ? (~v + 32'd1) : v;
        if (mag == 32'd0)
        begin
            tc.ch  = CHAR_ZERO;
            tc.fin = 1'b1;
            expected_text.push_back(tc);
            return;
        end
        while (mag != 32'd0)
        begin
            digits[nd] = 4'(mag % 32'd10);
            mag        = mag / 32'd10;
            nd++;
        end
        if (v[31])
        begin
            tc.ch  = CHAR_MINUS;
            tc.fin = 1'b0;
            expected_text.push_back(tc);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            tc.ch  = CHAR_ZERO + 7'(digits[i]);
            tc.fin = (i == 0);
            expected_text.push_back(tc);
        end
    endfunction

    // Offer one value, with random idle cycles ahead of it; valid stays high after
    task automatic send_value(input logic [31:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            value_valid <= 1'b0;
            value       <= $urandom;
            @(posedge clk);
        end
        value       <= v;
        value_valid <= 1'b1;
        @(posedge clk);
        while (!value_ready)
            @(posedge clk);
        predict_text(v);
    endtask

    // Random value with an evenly spread digit count and random sign, or one time in ten a raw random word
    function automatic logic [31:0] random_value();
        longint lo;
        longint hi;
        int     nd;
        logic [31:0] mag;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        nd = $urandom_range(1, 10);
        lo = (nd == 1) ? 0 : 64'd1;
        for (int i = 1; i < nd; i++)
            lo = lo * 10;
        hi = (nd == 10) ? 64'd2147483647 : lo * 10 - 1;
        if (nd == 1)
            hi = 9;
        mag = $urandom_range(32'(hi), 32'(lo));
        return $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
    endfunction

    // Zero, extremes, sign handling and digit-count boundaries
    task automatic test_directed_values();
        logic [31:0] cases [$];
        cases = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
                  32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                  32'd1000000000, 32'd999999999, -32'sd999999999,
                  32'd1234567890, -32'sd1234567890, 32'd5, -32'sd5,
                  32'd1000000, -32'sd1000000, 32'hAAAA_AAAA, 32'h5555_5555};
        foreach (cases[i])
            send_value(cases[i]);
    endtask

    task automatic test_random_values(input int count, input int send_pct,
                                      input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++)
            send_value(random_value());
    endtask

    // Output side: check each transfer, then pick next cycle's ready
    always @(posedge clk)
    begin
        text_char_t want;
        if (text_valid && text_ready)
        begin
            if (expected_text.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected character transfer: character=%0d last=%0b",
                         $time, character, last);
            end
            else
            begin
                want = expected_text.pop_front();
                if (character !== want.ch)
                begin
                    mismatch_count++;
                    $display("%0t: character mismatch: expected %0d, actual %0d",
                             $time, want.ch, character);
                end
                if (last !== want.fin)
                begin
                    mismatch_count++;
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.fin, last);
                end
            end
        end
        text_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: cycles with no transfer on either channel
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((value_valid && value_ready) || (text_valid && text_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_values();
        test_random_values(107, 27, 83);
        test_random_values(107, 83, 27);
        test_random_values(106, 0, 0);
        value_valid <= 1'b0;

        // Drain the outstanding characters, then let the block settle
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_text.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
